/* rtl/core/x86alu_pkg.sv */
`timescale 1ns / 1ps
package x86alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBB  = 5'd3,
        OP_MUL  = 5'd4,
        OP_IMUL = 5'd5,
        OP_DIV  = 5'd6,
        OP_IDIV = 5'd7,
        OP_MOD  = 5'd8,
        OP_IMOD = 5'd9,
        OP_AND  = 5'd10,
        OP_XOR  = 5'd11,
        OP_OR   = 5'd12,
        OP_SHL  = 5'd13,
        OP_SHR  = 5'd14,
        OP_SAR  = 5'd15,
        OP_SAL  = 5'd16
    } t_op;

    typedef enum logic [1:0] {
        W_8  = 2'd0,
        W_16 = 2'd1,
        W_32 = 2'd2,
        W_64 = 2'd3
    } t_wsel;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_EXEC = 3'd1,
        ST_DIV  = 3'd2,
        ST_FIN  = 3'd3,
        ST_DONE = 3'd4
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_last;
    } t_dp_sts;

    localparam int DIV_BITS = 64;
    localparam int CNT_W    = $clog2(DIV_BITS);

    function automatic logic [6:0] f_width(input t_wsel ws);
        case (ws)
            W_8:     f_width = 7'd8;
            W_16:    f_width = 7'd16;
            W_32:    f_width = 7'd32;
            default: f_width = 7'd64;
        endcase
    endfunction

    function automatic logic [63:0] f_mask(input t_wsel ws);
        case (ws)
            W_8:     f_mask = 64'h0000_0000_0000_00ff;
            W_16:    f_mask = 64'h0000_0000_0000_ffff;
            W_32:    f_mask = 64'h0000_0000_ffff_ffff;
            default: f_mask = 64'hffff_ffff_ffff_ffff;
        endcase
    endfunction

    function automatic logic [63:0] f_sext(input logic [63:0] v, input t_wsel ws);
        case (ws)
            W_8:     f_sext = {{56{v[7]}}, v[7:0]};
            W_16:    f_sext = {{48{v[15]}}, v[15:0]};
            W_32:    f_sext = {{32{v[31]}}, v[31:0]};
            default: f_sext = v;
        endcase
    endfunction

    function automatic logic f_msb(input logic [63:0] v, input t_wsel ws);
        case (ws)
            W_8:     f_msb = v[7];
            W_16:    f_msb = v[15];
            W_32:    f_msb = v[31];
            default: f_msb = v[63];
        endcase
    endfunction

endpackage

/* rtl/core/x86alu_ctrl.sv */
`timescale 1ns / 1ps
module x86alu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  x86alu_pkg::t_dp_sts i_sts,
    output x86alu_pkg::t_dp_cmd o_cmd
);

    x86alu_pkg::t_state r_state;
    x86alu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= x86alu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            x86alu_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = x86alu_pkg::ST_EXEC;
                end
            end
            x86alu_pkg::ST_EXEC: begin
                if (i_sts.is_mul) begin
                    o_cmd.mul_step = 1'b1;
                    n_state        = x86alu_pkg::ST_FIN;
                end else if (i_sts.is_div && !i_sts.div_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = x86alu_pkg::ST_DIV;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = x86alu_pkg::ST_DONE;
                end
            end
            x86alu_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = x86alu_pkg::ST_FIN;
                end
            end
            x86alu_pkg::ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = x86alu_pkg::ST_DONE;
            end
            x86alu_pkg::ST_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = x86alu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = x86alu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/x86alu_dp.sv */
`timescale 1ns / 1ps
module x86alu_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  x86alu_pkg::t_dp_cmd i_cmd,
    output x86alu_pkg::t_dp_sts o_sts,
    input  logic [4:0]          i_command,
    input  logic [63:0]         i_src_operand,
    input  logic [63:0]         i_dest_operand,
    input  logic [6:0]          i_op_width,
    output logic [63:0]         o_value,
    output logic                o_carry_out,
    output logic                o_overflow_out,
    output logic                o_sign_out,
    output logic                o_zero_out,
    output logic                o_parity_out,
    output logic                o_divide_error
);

    logic [4:0]                     r_op;
    logic [63:0]                    r_src;
    logic [63:0]                    r_dst;
    x86alu_pkg::t_wsel              r_ws;
    logic [63:0]                    r_prod;
    logic [63:0]                    r_dvd;
    logic [63:0]                    r_dvs;
    logic [64:0]                    r_rem;
    logic [x86alu_pkg::CNT_W-1:0]   r_cnt;
    logic                           r_na;
    logic                           r_nb;
    logic [63:0]                    r_value;
    logic                           r_derr;
    logic                           r_cf;
    logic                           r_of;
    logic                           r_sf;
    logic                           r_zf;
    logic                           r_pf;

    logic                           n_cf;
    logic                           n_of;
    logic                           n_sf;
    logic                           n_zf;
    logic                           n_pf;
    logic [63:0]                    n_value;
    logic                           n_derr;

    logic                           in_isdiv;
    x86alu_pkg::t_wsel              in_ws;
    logic [63:0]                    mask;
    logic [6:0]                     wid;
    logic [63:0]                    a;
    logic [63:0]                    b;
    logic [63:0]                    sext_a;
    logic [63:0]                    sext_b;
    logic                           is_signed_div;
    logic                           is_imul;
    logic [32:0]                    mul_x;
    logic [32:0]                    mul_y;
    logic [65:0]                    mul_p;
    logic [64:0]                    rem_sh;
    logic [64:0]                    rem_diff;

    assign in_isdiv = (i_command >= x86alu_pkg::OP_DIV) && (i_command <= x86alu_pkg::OP_IMOD);

    always_comb begin
        if (i_op_width == 7'd8) begin
            in_ws = x86alu_pkg::W_8;
        end else if (i_op_width == 7'd16) begin
            in_ws = x86alu_pkg::W_16;
        end else if (in_isdiv && i_op_width != 7'd32) begin
            in_ws = x86alu_pkg::W_64;
        end else begin
            in_ws = x86alu_pkg::W_32;
        end
    end

    assign mask = x86alu_pkg::f_mask(r_ws);
    assign wid  = x86alu_pkg::f_width(r_ws);
    assign a    = r_dst & mask;
    assign b    = r_src & mask;

    assign sext_a = x86alu_pkg::f_sext(a, r_ws);
    assign sext_b = x86alu_pkg::f_sext(b, r_ws);

    assign is_signed_div = (r_op == x86alu_pkg::OP_IDIV) || (r_op == x86alu_pkg::OP_IMOD);
    assign is_imul       = (r_op == x86alu_pkg::OP_IMUL);

    assign o_sts.is_mul   = (r_op == x86alu_pkg::OP_MUL) || is_imul;
    assign o_sts.is_div   = (r_op >= x86alu_pkg::OP_DIV) && (r_op <= x86alu_pkg::OP_IMOD);
    assign o_sts.div_zero = (b == 64'd0);
    assign o_sts.div_last = (r_cnt == x86alu_pkg::CNT_W'(x86alu_pkg::DIV_BITS - 1));

    assign mul_x = is_imul ? sext_a[32:0] : {1'b0, a[31:0]};
    assign mul_y = is_imul ? sext_b[32:0] : {1'b0, b[31:0]};
    assign mul_p = $signed(mul_x) * $signed(mul_y);

    assign rem_sh   = {r_rem[63:0], r_dvd[63]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_command;
            r_src <= i_src_operand;
            r_dst <= i_dest_operand;
            r_ws  <= in_ws;
        end
        if (i_cmd.mul_step) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.div_init) begin
            r_na  <= is_signed_div && x86alu_pkg::f_msb(a, r_ws);
            r_nb  <= is_signed_div && x86alu_pkg::f_msb(b, r_ws);
            r_dvd <= (is_signed_div && x86alu_pkg::f_msb(a, r_ws))
                     ? 64'd0 - x86alu_pkg::f_sext(a, r_ws) : a;
            r_dvs <= (is_signed_div && x86alu_pkg::f_msb(b, r_ws))
                     ? 64'd0 - x86alu_pkg::f_sext(b, r_ws) : b;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!rem_diff[64]) begin
                r_rem <= rem_diff;
            end else begin
                r_rem <= rem_sh;
            end
            r_dvd <= {r_dvd[62:0], !rem_diff[64]};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.finish) begin
            r_value <= n_value;
            r_derr  <= n_derr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf <= 1'b0;
            r_of <= 1'b0;
            r_sf <= 1'b0;
            r_zf <= 1'b0;
            r_pf <= 1'b0;
        end else if (i_cmd.finish) begin
            r_cf <= n_cf;
            r_of <= n_of;
            r_sf <= n_sf;
            r_zf <= n_zf;
            r_pf <= n_pf;
        end
    end

    always_comb begin
        logic [33:0] sum;
        logic [33:0] dif;
        logic        cin;
        logic [63:0] r;
        logic        set_szp;
        logic [5:0]  cnt;
        logic [63:0] sar_v;
        logic [63:0] q;

        n_cf    = r_cf;
        n_of    = r_of;
        n_sf    = r_sf;
        n_zf    = r_zf;
        n_pf    = r_pf;
        n_value = 64'd0;
        n_derr  = 1'b0;
        set_szp = 1'b0;
        r       = 64'd0;
        q       = 64'd0;
        cin     = 1'b0;
        sum     = '0;
        dif     = '0;
        sar_v   = '0;
        cnt     = (r_src > {57'd0, wid}) ? wid[5:0] : r_src[5:0];

        case (r_op)
            x86alu_pkg::OP_ADD, x86alu_pkg::OP_ADC: begin
                cin     = (r_op == x86alu_pkg::OP_ADC) && r_cf;
                sum     = {2'b00, a[31:0]} + {2'b00, b[31:0]} + {33'd0, cin};
                r       = {30'd0, sum} & mask;
                n_cf    = sum[wid[5:0]];
                n_of    = x86alu_pkg::f_msb((a ^ r) & (b ^ r), r_ws);
                set_szp = 1'b1;
            end
            x86alu_pkg::OP_SUB, x86alu_pkg::OP_SBB: begin
                cin     = (r_op == x86alu_pkg::OP_SBB) && r_cf;
                dif     = {2'b00, a[31:0]} - {2'b00, b[31:0]} - {33'd0, cin};
                r       = {30'd0, dif} & mask;
                n_cf    = dif[33];
                n_of    = x86alu_pkg::f_msb((a ^ b) & (a ^ r), r_ws);
                set_szp = 1'b1;
            end
            x86alu_pkg::OP_MUL: begin
                n_value = r_prod;
                n_cf    = (r_prod & ~mask) != 64'd0;
                n_of    = (r_prod & ~mask) != 64'd0;
            end
            x86alu_pkg::OP_IMUL: begin
                case (r_ws)
                    x86alu_pkg::W_8:  n_value = {48'd0, r_prod[15:0]};
                    x86alu_pkg::W_16: n_value = {32'd0, r_prod[31:0]};
                    default:          n_value = r_prod;
                endcase
            end
            x86alu_pkg::OP_DIV, x86alu_pkg::OP_IDIV,
            x86alu_pkg::OP_MOD, x86alu_pkg::OP_IMOD: begin
                if (b == 64'd0) begin
                    n_derr = 1'b1;
                end else begin
                    if (r_op == x86alu_pkg::OP_DIV || r_op == x86alu_pkg::OP_IDIV) begin
                        q = (r_na != r_nb) ? 64'd0 - r_dvd : r_dvd;
                    end else begin
                        q = r_na ? 64'd0 - r_rem[63:0] : r_rem[63:0];
                    end
                    n_value = q & mask;
                end
            end
            x86alu_pkg::OP_AND, x86alu_pkg::OP_XOR, x86alu_pkg::OP_OR: begin
                if (r_op == x86alu_pkg::OP_AND) begin
                    r = a & b;
                end else if (r_op == x86alu_pkg::OP_XOR) begin
                    r = a ^ b;
                end else begin
                    r = a | b;
                end
                n_cf    = 1'b0;
                n_of    = 1'b0;
                set_szp = 1'b1;
            end
            x86alu_pkg::OP_SHL, x86alu_pkg::OP_SAL: begin
                if (cnt == 6'd0) begin
                    n_value = a;
                end else begin
                    r       = (a << cnt) & mask;
                    n_cf    = a[6'(wid[5:0] - cnt)];
                    if (cnt == 6'd1) begin
                        n_of = x86alu_pkg::f_msb(r, r_ws) ^ n_cf;
                    end
                    set_szp = 1'b1;
                end
            end
            x86alu_pkg::OP_SHR, x86alu_pkg::OP_SAR: begin
                if (cnt == 6'd0) begin
                    n_value = a;
                end else begin
                    sar_v = $signed(x86alu_pkg::f_sext(a, r_ws)) >>> cnt;
                    r     = (r_op == x86alu_pkg::OP_SHR) ? (a >> cnt) : (sar_v & mask);
                    n_cf  = a[6'(cnt - 6'd1)];
                    if (cnt == 6'd1) begin
                        n_of = (r_op == x86alu_pkg::OP_SHR) && x86alu_pkg::f_msb(a, r_ws);
                    end
                    set_szp = 1'b1;
                end
            end
            default: begin
                n_value = 64'd0;
            end
        endcase

        if (set_szp) begin
            n_value = r;
            n_sf    = x86alu_pkg::f_msb(r, r_ws);
            n_zf    = (r == 64'd0);
            n_pf    = ~^r[7:0];
        end
    end

    assign o_value        = r_value;
    assign o_divide_error = r_derr;
    assign o_carry_out    = r_cf;
    assign o_overflow_out = r_of;
    assign o_sign_out     = r_sf;
    assign o_zero_out     = r_zf;
    assign o_parity_out   = r_pf;

endmodule

/* rtl/core/x86_alu_with_flags_unit.sv */
`timescale 1ns / 1ps
// Channel  Valid    Ready    Payload
// in       i_valid  o_ready  i_command, i_src_operand, i_dest_operand, i_op_width
// out      o_valid  i_ready  o_value, o_carry_out .. o_parity_out, o_divide_error
//
// One item at a time. Add, logic and shift ops: result registered in ST_EXEC.
// mul/imul: one registered 33x33 multiply, then ST_FIN. Division: ST_DIV runs
// the one-bit-per-cycle restoring divider, always 64 steps, then ST_FIN.
// A zero divisor skips the divider. Reset clears the flags and the sequencer.
// The result beat holds until taken; the next item is accepted after that.
module x86_alu_with_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_command,
    input  logic [63:0] i_src_operand,
    input  logic [63:0] i_dest_operand,
    input  logic [6:0]  i_op_width,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic        o_carry_out,
    output logic        o_overflow_out,
    output logic        o_sign_out,
    output logic        o_zero_out,
    output logic        o_parity_out,
    output logic        o_divide_error
);

    x86alu_pkg::t_dp_cmd dp_cmd;
    x86alu_pkg::t_dp_sts dp_sts;

    x86alu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    x86alu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_command      (i_command),
        .i_src_operand  (i_src_operand),
        .i_dest_operand (i_dest_operand),
        .i_op_width     (i_op_width),
        .o_value        (o_value),
        .o_carry_out    (o_carry_out),
        .o_overflow_out (o_overflow_out),
        .o_sign_out     (o_sign_out),
        .o_zero_out     (o_zero_out),
        .o_parity_out   (o_parity_out),
        .o_divide_error (o_divide_error)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while a result is pending");

    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_value == 64'd0))
        else $error("divide error with nonzero value");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result shown in the cycle after accept");
`endif

endmodule
